FILE: hdl/atsl_pkg.sv
// ----------------------------------------------------------------------------
// atsl_pkg
// Shared types and constants for the address to symbol lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package atsl_pkg;

  localparam int ADDR_W = 64;
  localparam int OFF_W  = 32;
  localparam int IDX_W  = 16;
  localparam int CNT_W  = 17;
  localparam int REG_W  = 2;

  localparam int DEFAULT_MAX_SYMBOLS = 65536;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_RELATIVE_BASE = 2'd0;
  localparam logic [REG_W-1:0] REG_REGION_START  = 2'd1;
  localparam logic [REG_W-1:0] REG_REGION_END    = 2'd2;
  localparam logic [REG_W-1:0] REG_SYMBOL_COUNT  = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] relative_base;
    logic [ADDR_W-1:0] region_start;
    logic [ADDR_W-1:0] region_end;
    logic [CNT_W-1:0]  symbol_count;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/address_to_symbol_lookup.sv
// ----------------------------------------------------------------------------
// address_to_symbol_lookup
// Resolves an address to the containing symbol of a sorted offset table.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_ready    | kind, entry_index, entry_offset,
//           |                        | query_address
//  output   | out_valid / out_ready  | found, symbol_index, symbol_start,
//           |                        | offset_in_symbol
//  config   | cfg_write              | cfg_index, cfg_data
//
//  Load: written into the table as it is accepted. Lookup: accept, bisection
//  steps, the start entry, steps back over equal entries, a forward scan for
//  a higher entry, the result. Out of region or fewer than two entries: straight
//  to the result. One table read port paces every step.
//  Reset clears control and registers only; the table holds no valid state.
//  A result waits in the output register; a second one holds off the input.
// ----------------------------------------------------------------------------
`default_nettype none

module address_to_symbol_lookup #(
  parameter int MAX_SYMBOLS = atsl_pkg::DEFAULT_MAX_SYMBOLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [atsl_pkg::REG_W-1:0]    cfg_index,
  input  logic [atsl_pkg::ADDR_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [atsl_pkg::IDX_W-1:0]    entry_index,
  input  logic [atsl_pkg::OFF_W-1:0]    entry_offset,
  input  logic [atsl_pkg::ADDR_W-1:0]   query_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [atsl_pkg::IDX_W-1:0]    symbol_index,
  output logic [atsl_pkg::ADDR_W-1:0]   symbol_start,
  output logic [atsl_pkg::ADDR_W-1:0]   offset_in_symbol
);

  import atsl_pkg::*;

  localparam int AW = $clog2(MAX_SYMBOLS);

  cfg_t cfg;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [OFF_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [OFF_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RELATIVE_BASE: cfg.relative_base <= cfg_data;
        REG_REGION_START:  cfg.region_start  <= cfg_data;
        REG_REGION_END:    cfg.region_end    <= cfg_data;
        REG_SYMBOL_COUNT:  cfg.symbol_count  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  atsl_ctrl #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .AW          (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .entry_index      (entry_index),
    .entry_offset     (entry_offset),
    .query_address    (query_address),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found            (found),
    .symbol_index     (symbol_index),
    .symbol_start     (symbol_start),
    .offset_in_symbol (offset_in_symbol)
  );

  atsl_mem #(
    .DEPTH (MAX_SYMBOLS),
    .DW    (OFF_W),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: hdl/atsl_mem.sv
// ----------------------------------------------------------------------------
// atsl_mem
// Offset table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module atsl_mem #(
  parameter int DEPTH = 65536,
  parameter int DW    = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/atsl_ctrl.sv
// ----------------------------------------------------------------------------
// atsl_ctrl
// Search sequencer: bisection, step back over equal entries, forward scan,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module atsl_ctrl #(
  parameter int MAX_SYMBOLS = 65536,
  parameter int AW          = $clog2(MAX_SYMBOLS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  atsl_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [atsl_pkg::IDX_W-1:0]    entry_index,
  input  logic [atsl_pkg::OFF_W-1:0]    entry_offset,
  input  logic [atsl_pkg::ADDR_W-1:0]   query_address,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [atsl_pkg::OFF_W-1:0]    mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [atsl_pkg::OFF_W-1:0]    mem_rdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [atsl_pkg::IDX_W-1:0]    symbol_index,
  output logic [atsl_pkg::ADDR_W-1:0]   symbol_start,
  output logic [atsl_pkg::ADDR_W-1:0]   offset_in_symbol
);

  import atsl_pkg::*;

  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BS_ISSUE,
    S_BS_CMP,
    S_ST_ISSUE,
    S_ST_CAP,
    S_BK_ISSUE,
    S_BK_CMP,
    S_FW_CHK,
    S_FW_CMP,
    S_DONE
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] addr;
  logic [CW-1:0]     n;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     mid_r;
  logic [CW-1:0]     fi;
  logic [OFF_W-1:0]  start_off;
  logic [ADDR_W-1:0] start_addr;

  logic              res_found;
  logic [IDX_W-1:0]  res_index;
  logic [ADDR_W-1:0] res_start;
  logic [ADDR_W-1:0] res_offset;

  logic              accept;
  logic [CW-1:0]     n_sat;
  logic              in_region;
  logic [CW-1:0]     mid;
  logic [ADDR_W-1:0] rd_addr;
  logic              bs_le;
  logic [CW-1:0]     lo_next;
  logic [CW-1:0]     hi_next;
  logic [CW-1:0]     lo_dec;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;

  assign n_sat     = (32'(cfg.symbol_count) > 32'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS)
                                                                 : CW'(cfg.symbol_count);
  assign in_region = (query_address >= cfg.region_start) &&
                     (query_address < cfg.region_end);

  // table writes happen only while idle, so they never meet a pending read
  assign mem_we    = accept && (kind == KIND_LOAD) &&
                     (32'(entry_index) < 32'(MAX_SYMBOLS));
  assign mem_waddr = AW'(entry_index);
  assign mem_wdata = entry_offset;

  assign mid     = lo + ((hi - lo) >> 1);
  assign rd_addr = cfg.relative_base + ADDR_W'(mem_rdata);
  assign bs_le   = (rd_addr <= addr);
  assign lo_next = bs_le ? mid_r : lo;
  assign hi_next = bs_le ? hi : mid_r;
  assign lo_dec  = lo - CW'(1);

  always_comb begin
    case (state)
      S_BS_ISSUE: mem_raddr = AW'(mid);
      S_BK_ISSUE: mem_raddr = AW'(lo_dec);
      S_FW_CHK:   mem_raddr = AW'(fi);
      default:    mem_raddr = AW'(lo);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // S_DONE handles the output register itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (kind == KIND_LOOKUP)) begin
            addr       <= query_address;
            n          <= n_sat;
            lo         <= '0;
            hi         <= n_sat;
            res_found  <= 1'b0;
            res_index  <= '0;
            res_start  <= '0;
            res_offset <= '0;
            if (in_region && (n_sat >= CW'(2))) begin
              state <= S_BS_ISSUE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_BS_ISSUE: begin
          mid_r <= mid;
          state <= S_BS_CMP;
        end
        S_BS_CMP: begin
          lo <= lo_next;
          hi <= hi_next;
          if ((hi_next - lo_next) > CW'(1)) begin
            state <= S_BS_ISSUE;
          end else begin
            state <= S_ST_ISSUE;
          end
        end
        S_ST_ISSUE: begin
          state <= S_ST_CAP;
        end
        S_ST_CAP: begin
          start_off  <= mem_rdata;
          start_addr <= rd_addr;
          if (lo != '0) begin
            state <= S_BK_ISSUE;
          end else begin
            fi    <= lo + CW'(1);
            state <= S_FW_CHK;
          end
        end
        S_BK_ISSUE: begin
          state <= S_BK_CMP;
        end
        S_BK_CMP: begin
          // equal offsets give equal addresses, so compare the raw offsets
          if (mem_rdata == start_off) begin
            lo <= lo_dec;
            if (lo_dec != '0) begin
              state <= S_BK_ISSUE;
            end else begin
              fi    <= lo;
              state <= S_FW_CHK;
            end
          end else begin
            fi    <= lo + CW'(1);
            state <= S_FW_CHK;
          end
        end
        S_FW_CHK: begin
          if (fi < n) begin
            state <= S_FW_CMP;
          end else begin
            state <= S_DONE;
          end
        end
        S_FW_CMP: begin
          if (rd_addr > start_addr) begin
            res_found  <= 1'b1;
            res_index  <= IDX_W'(lo);
            res_start  <= start_addr;
            res_offset <= addr - start_addr;
            state      <= S_DONE;
          end else begin
            fi    <= fi + CW'(1);
            state <= S_FW_CHK;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            found            <= res_found;
            symbol_index     <= res_index;
            symbol_start     <= res_start;
            offset_in_symbol <= res_offset;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: bench/address_to_symbol_lookup_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_to_symbol_lookup_test
// Self-checking bench for the sorted symbol table lookup block: loads tables
// of several shapes and sizes, sweeps base and region settings, and compares
// every lookup result against an in-bench model of the search.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                          found;
  logic [atsl_pkg::IDX_W-1:0]    symbol_index;
  logic [atsl_pkg::ADDR_W-1:0]   symbol_start;
  logic [atsl_pkg::ADDR_W-1:0]   offset_in_symbol;
} lookup_result_t;

class symbol_scoreboard;
  logic [atsl_pkg::OFF_W-1:0]  offsets [atsl_pkg::DEFAULT_MAX_SYMBOLS];
  logic [atsl_pkg::ADDR_W-1:0] base;
  logic [atsl_pkg::ADDR_W-1:0] region_lo;
  logic [atsl_pkg::ADDR_W-1:0] region_hi;
  logic [atsl_pkg::CNT_W-1:0]  count;
  lookup_result_t              expected_lookups [$];
  int unsigned                 errors;
  int unsigned                 loads;
  int unsigned                 lookups;
  int unsigned                 hits;

  function new();
    base = '0;
    region_lo = '0;
    region_hi = '0;
    count = '0;
    errors = 0;
    loads = 0;
    lookups = 0;
    hits = 0;
  endfunction

  function void set_reg(input logic [atsl_pkg::REG_W-1:0] idx,
                        input logic [atsl_pkg::ADDR_W-1:0] data);
    case (idx)
      atsl_pkg::REG_RELATIVE_BASE: base = data;
      atsl_pkg::REG_REGION_START:  region_lo = data;
      atsl_pkg::REG_REGION_END:    region_hi = data;
      atsl_pkg::REG_SYMBOL_COUNT:  count = data[atsl_pkg::CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [atsl_pkg::ADDR_W-1:0] entry_addr(input int unsigned pos);
    return base + {32'b0, offsets[pos]};
  endfunction

  function lookup_result_t resolve_address(input logic [atsl_pkg::ADDR_W-1:0] addr);
    lookup_result_t              r;
    int unsigned                 n;
    int unsigned                 lo;
    int unsigned                 hi;
    int unsigned                 mid;
    int unsigned                 i;
    logic [atsl_pkg::ADDR_W-1:0] start_addr;
    bit                          have_next;
    r = '0;
    if (!(addr >= region_lo && addr < region_hi))
      return r;
    n = 32'(count);
    if (n > atsl_pkg::DEFAULT_MAX_SYMBOLS)
      n = atsl_pkg::DEFAULT_MAX_SYMBOLS;
    if (n < 2)
      return r;
    lo = 0;
    hi = n;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (entry_addr(mid) <= addr)
        lo = mid;
      else
        hi = mid;
    end
    // back up to the first of a run of equal addresses
    while (lo != 0 && entry_addr(lo - 1) == entry_addr(lo))
      lo--;
    start_addr = entry_addr(lo);
    have_next = 1'b0;
    i = lo + 1;
    while (!have_next && i < n) begin
      if (entry_addr(i) > start_addr)
        have_next = 1'b1;
      i++;
    end
    if (!have_next)
      return r;
    r.found = 1'b1;
    r.symbol_index = lo[atsl_pkg::IDX_W-1:0];
    r.symbol_start = start_addr;
    r.offset_in_symbol = addr - start_addr;
    return r;
  endfunction

  function void note_input(input logic k,
                           input logic [atsl_pkg::IDX_W-1:0] idx,
                           input logic [atsl_pkg::OFF_W-1:0] off,
                           input logic [atsl_pkg::ADDR_W-1:0] addr);
    if (k == atsl_pkg::KIND_LOAD) begin
      offsets[idx] = off;
      loads++;
    end else begin
      expected_lookups.push_back(resolve_address(addr));
      lookups++;
    end
  endfunction

  function void check_result(input logic got_found,
                             input logic [atsl_pkg::IDX_W-1:0] got_index,
                             input logic [atsl_pkg::ADDR_W-1:0] got_start,
                             input logic [atsl_pkg::ADDR_W-1:0] got_offset);
    lookup_result_t e;
    if (expected_lookups.size() == 0) begin
      $error("lookup result with no lookup outstanding");
      errors++;
      return;
    end
    e = expected_lookups.pop_front();
    if (e.found)
      hits++;
    if (got_found !== e.found) begin
      $error("found: expected %0d, got %0d", e.found, got_found);
      errors++;
    end
    if (got_index !== e.symbol_index) begin
      $error("symbol_index: expected %0d, got %0d", e.symbol_index, got_index);
      errors++;
    end
    if (got_start !== e.symbol_start) begin
      $error("symbol_start: expected %h, got %h", e.symbol_start, got_start);
      errors++;
    end
    if (got_offset !== e.offset_in_symbol) begin
      $error("offset_in_symbol: expected %h, got %h", e.offset_in_symbol, got_offset);
      errors++;
    end
  endfunction
endclass

module address_to_symbol_lookup_test;
  import atsl_pkg::*;

  localparam int unsigned TABLE_DEPTH  = DEFAULT_MAX_SYMBOLS;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 2000000;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [REG_W-1:0]  cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = KIND_LOAD;
  logic [IDX_W-1:0]  entry_index = '0;
  logic [OFF_W-1:0]  entry_offset = '0;
  logic [ADDR_W-1:0] query_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              found;
  logic [IDX_W-1:0]  symbol_index;
  logic [ADDR_W-1:0] symbol_start;
  logic [ADDR_W-1:0] offset_in_symbol;

  symbol_scoreboard sb = new();

  bit          quiet_sender = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned settings_done = 0;
  // full-depth table entries that currently hold their generated offset
  bit          big_loaded [TABLE_DEPTH];

  address_to_symbol_lookup u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .entry_index      (entry_index),
    .entry_offset     (entry_offset),
    .query_address    (query_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found            (found),
    .symbol_index     (symbol_index),
    .symbol_start     (symbol_start),
    .offset_in_symbol (offset_in_symbol)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item and hold it until the block takes it. Returns in the
  // time step of the accepting edge.
  task automatic send_item(input logic k, input logic [IDX_W-1:0] idx,
                           input logic [OFF_W-1:0] off, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!quiet_sender)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    entry_index   <= idx;
    entry_offset  <= off;
    query_address <= addr;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k, idx, off, addr);
  endtask

  task automatic load(input int unsigned idx, input logic [OFF_W-1:0] off);
    send_item(KIND_LOAD, IDX_W'(idx), off, {$urandom, $urandom});
  endtask

  task automatic lookup(input logic [ADDR_W-1:0] addr);
    send_item(KIND_LOOKUP, IDX_W'($urandom), OFF_W'($urandom), addr);
  endtask

  // Wait for every outstanding lookup, then give the block time to go idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [REG_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] lo,
                           input logic [ADDR_W-1:0] hi, input int unsigned cnt);
    settle();
    put_reg(REG_RELATIVE_BASE, base);
    put_reg(REG_REGION_START, lo);
    put_reg(REG_REGION_END, hi);
    put_reg(REG_SYMBOL_COUNT, ADDR_W'(cnt));
    cfg_write <= 1'b0;
    settings_done++;
  endtask

  // Table shapes: 0 tight sorted with duplicates, 1 sorted over the whole
  // offset range, 2 unsorted, 3 long runs of equal offsets.
  task automatic fill_table(input int unsigned n, input int unsigned shape);
    logic [OFF_W:0] level;
    int unsigned    span;
    level = (shape == 1) ? (OFF_W+1)'($urandom_range(0, 255))
                         : {1'b0, $urandom} >> $urandom_range(1, 32);
    span = 32'hFFFF_FFFF / (n + 1);
    for (int unsigned i = 0; i < n; i++) begin
      case (shape)
        0:       level = level + (OFF_W+1)'(($urandom_range(0, 3) == 0) ? 0
                                                          : $urandom_range(1, 64));
        1:       level = level + (OFF_W+1)'($urandom_range(0, span));
        2:       level = {1'b0, $urandom};
        default: level = level + (OFF_W+1)'(($urandom_range(0, 7) == 0)
                                            ? $urandom_range(1, 1000) : 0);
      endcase
      if (level[OFF_W])
        level = {1'b0, {OFF_W{1'b1}}};
      load(i, level[OFF_W-1:0]);
    end
  endtask

  // Addresses mostly land on or next to table entries and region edges.
  function automatic logic [ADDR_W-1:0] pick_address(input int unsigned filled);
    int unsigned       sel;
    int unsigned       pos;
    logic [ADDR_W-1:0] near;
    sel = $urandom_range(0, 9);
    if (filled == 0 || sel == 0)
      return {$urandom, $urandom};
    if (sel <= 2) begin
      case ($urandom_range(0, 3))
        0:       return sb.region_lo;
        1:       return sb.region_lo - 1;
        2:       return sb.region_hi;
        default: return sb.region_hi - 1;
      endcase
    end
    pos = $urandom_range(0, filled - 1);
    near = sb.entry_addr(pos);
    case ($urandom_range(0, 4))
      0:       return near;
      1:       return near - 1;
      2:       return near + 1;
      3:       return near - $urandom_range(0, 255);
      default: return near + $urandom_range(0, 255);
    endcase
  endfunction

  // Mostly lookups; stray loads land anywhere, reordering the table at times.
  task automatic run_stream(input int unsigned filled, input int unsigned items);
    for (int unsigned i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 15)
        load($urandom_range(0, TABLE_DEPTH - 1), OFF_W'($urandom));
      else
        lookup(pick_address(filled));
    end
  endtask

  task automatic random_setting(input bit pressure);
    int unsigned       n;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 48);
    fill_table(n, $urandom_range(0, 3));
    settle();
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = {$urandom, $urandom};
      2:       base = ALL_ONES;
      default: base = ALL_ONES - $urandom_range(0, 32'h7FFF_FFFF);
    endcase
    sb.base = base;
    case ($urandom_range(0, 4))
      0, 1: begin
        lo = '0;
        hi = ALL_ONES;
      end
      2: begin
        lo = (n >= 2) ? sb.entry_addr($urandom_range(0, n - 1)) : {$urandom, $urandom};
        hi = (n >= 2) ? sb.entry_addr($urandom_range(0, n - 1)) + $urandom_range(0, 64)
                      : {$urandom, $urandom};
      end
      3: begin
        lo = {$urandom, $urandom};
        hi = lo - $urandom_range(0, 5);
      end
      default: begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
    endcase
    configure(base, lo, hi, n);
    if (pressure)
      hold_off_req = 1'b1;
    run_stream(n, 40);
  endtask

  // Full-depth table: pairs of equal offsets rising in steps of 4096.
  function automatic logic [OFF_W-1:0] big_offset(input int unsigned pos);
    return OFF_W'(pos >> 1) << 12;
  endfunction

  function automatic logic [ADDR_W-1:0] big_addr(input int unsigned pos);
    return sb.base + {32'b0, big_offset(pos)};
  endfunction

  task automatic big_load(input int unsigned pos);
    if (!big_loaded[pos]) begin
      load(pos, big_offset(pos));
      big_loaded[pos] = 1'b1;
    end
  endtask

  // Walk the search the block will do on the full-depth table and load only
  // the entries it reads, then issue the lookup.
  task automatic big_lookup(input logic [ADDR_W-1:0] addr);
    int unsigned       n;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mid;
    int unsigned       i;
    bit                stop;
    logic [ADDR_W-1:0] start_addr;
    n = 32'(sb.count);
    if (n > TABLE_DEPTH)
      n = TABLE_DEPTH;
    if (addr >= sb.region_lo && addr < sb.region_hi && n >= 2) begin
      lo = 0;
      hi = n;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        big_load(mid);
        if (big_addr(mid) <= addr)
          lo = mid;
        else
          hi = mid;
      end
      big_load(lo);
      stop = 1'b0;
      while (!stop && lo != 0) begin
        big_load(lo - 1);
        if (big_offset(lo - 1) == big_offset(lo))
          lo--;
        else
          stop = 1'b1;
      end
      start_addr = big_addr(lo);
      stop = 1'b0;
      i = lo + 1;
      while (!stop && i < n) begin
        big_load(i);
        if (big_addr(i) > start_addr)
          stop = 1'b1;
        i++;
      end
    end
    lookup(addr);
  endtask

  function automatic logic [ADDR_W-1:0] big_address();
    int unsigned pos;
    pos = $urandom_range(0, TABLE_DEPTH - 1);
    case ($urandom_range(0, 4))
      0:       return big_addr(pos);
      1:       return big_addr(pos) + $urandom_range(1, 4095);
      2:       return sb.base - 1;           // below the first entry
      3:       return ALL_ONES;              // above every entry
      default: return big_addr(pos) - 1;
    endcase
  endfunction

  // Receiver: switches between four stall patterns, and on
  // request refuses results for a long stretch so the block backs up.
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned beat;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(found, symbol_index, symbol_start, offset_in_symbol);
      if (hold_off_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (beat % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [OFF_W-1:0] small_table [8];
    int unsigned      big_counts [4];
    logic [ADDR_W-1:0] big_base;
    small_table = '{32'h10, 32'h20, 32'h20, 32'h20, 32'h40, 32'h80, 32'h80, 32'hFFFF_FFFF};
    big_counts = '{TABLE_DEPTH, 17'h1FFFF, TABLE_DEPTH + 1, TABLE_DEPTH - 1};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state has an empty region
    lookup('0);
    for (int unsigned i = 0; i < 8; i++)
      load(i, small_table[i]);
    configure(64'h1000, '0, ALL_ONES, 1);
    lookup(64'h1010);                      // a single entry has no follower
    configure(64'h1000, '0, ALL_ONES, 8);
    lookup(64'h1000);                      // below the first entry, offset wraps
    lookup(64'h1020);                      // lands on a run of equal entries
    lookup(64'h1035);
    lookup(64'h1080);
    lookup(64'h1_0000_0FFF);               // last entry, nothing above it
    lookup(ALL_ONES);                      // region end is exclusive
    configure(64'h1000, 64'h1030, 64'h1050, 8);
    lookup(64'h102F);
    lookup(64'h1030);
    lookup(64'h104F);
    lookup(64'h1050);
    configure(64'h1000, ALL_ONES, '0, 8);
    lookup(64'h1040);                      // start above end
    configure(64'hFFFF_FFFF_FFFF_FF00, '0, ALL_ONES, 8);
    lookup(64'hFFFF_FFFF_FFFF_FF45);       // last entry wraps past zero: unsorted
    lookup(64'h10);

    for (int unsigned p = 0; p < 9; p++)
      random_setting(p == 1);

    // full-depth counts at, just below and beyond the table size; only the entries each
    // search touches get loaded
    settle();
    big_base = {$urandom, $urandom} >> 1;
    quiet_sender = 1'b1;
    foreach (big_counts[c]) begin
      configure(big_base, '0, ALL_ONES, big_counts[c]);
      for (int unsigned k = 0; k < ((c == 0) ? 4 : 2); k++)
        big_lookup(big_address());
    end
    quiet_sender = 1'b0;

    settle();
    $display("Covered %0d table loads and %0d lookups, %0d of them resolving to a symbol.",
             sb.loads, sb.lookups, sb.hits);
    $display("Went through %0d register settings, table sizes from 0 to %0d entries.",
             settings_done, TABLE_DEPTH);
    if (sb.errors == 0 && sb.expected_lookups.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
